### rtl/dpcr_pkg.sv
// Shared widths, constants, keyframe tables and types of the day phase colour ramp.
`default_nettype none

package dpcr_pkg;

    // Field and state widths
    localparam int PHASE_BITS   = 16;
    localparam int DAY_BITS     = 16;
    localparam int DUR_BITS     = 24;
    localparam int ELAPSED_BITS = 16;
    localparam int CHAN_BITS    = 8;
    localparam int PERIOD_BITS  = 3;

    // APB register map
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 3;
    localparam logic [0:0] REG_DAY_DURATION = 1'b0;

    localparam logic [DUR_BITS-1:0]   DUR_DEFAULT = DUR_BITS'(120000);
    localparam logic [PHASE_BITS-1:0] PHASE_RESET =
        PHASE_BITS'((18 * (2 ** PHASE_BITS)) / 100);
    localparam logic [DAY_BITS-1:0]   DAY_RESET = DAY_BITS'(1);

    // Phase scaled by 100, keyframe offsets and the colour product
    localparam int PCT_BITS    = 7;
    localparam int SPAN_BITS   = 5;
    localparam int SCALED_BITS = PHASE_BITS + PCT_BITS;
    localparam int OFF_BITS    = PHASE_BITS + SPAN_BITS;
    localparam int PROD_BITS   = OFF_BITS + CHAN_BITS;
    localparam int X_BITS      = CHAN_BITS + SPAN_BITS;

    // Shared divider
    localparam int REM_BITS  = DUR_BITS + 1;
    localparam int SRC_BITS  = (PHASE_BITS > CHAN_BITS) ? PHASE_BITS : CHAN_BITS;
    localparam int STEP_BITS = $clog2(SRC_BITS + 1);

    // Keyframes, positions in hundredths of a day
    localparam int NUM_KEYS      = 6;
    localparam int SEG_COUNT     = NUM_KEYS - 1;
    localparam int SEG_BITS      = 3;
    localparam int NUM_CHANS     = 4;
    localparam int CHAN_IDX_BITS = 2;

    localparam logic [PCT_BITS-1:0] KEY_POS [NUM_KEYS] = '{
        7'd0, 7'd15, 7'd45, 7'd60, 7'd82, 7'd100
    };
    localparam logic [SPAN_BITS-1:0] SEG_SPAN [SEG_COUNT] = '{
        5'd15, 5'd30, 5'd15, 5'd22, 5'd18
    };
    localparam logic [CHAN_BITS-1:0] KEY_RGBA [NUM_KEYS][NUM_CHANS] = '{
        '{8'd255, 8'd140, 8'd50,  8'd70},
        '{8'd255, 8'd220, 8'd100, 8'd0},
        '{8'd180, 8'd60,  8'd20,  8'd55},
        '{8'd20,  8'd20,  8'd80,  8'd130},
        '{8'd10,  8'd10,  8'd55,  8'd155},
        '{8'd255, 8'd140, 8'd50,  8'd70}
    };

    // Period breaks and night window
    localparam logic [PCT_BITS-1:0] BRK_DAY      = 7'd10;
    localparam logic [PCT_BITS-1:0] BRK_DUSK     = 7'd45;
    localparam logic [PCT_BITS-1:0] BRK_NIGHT    = 7'd60;
    localparam logic [PCT_BITS-1:0] BRK_MIDNIGHT = 7'd82;
    localparam logic [PCT_BITS-1:0] BRK_PREDAWN  = 7'd97;
    localparam logic [PCT_BITS-1:0] NIGHT_START  = 7'd55;

    typedef enum logic [PERIOD_BITS-1:0] {
        PERIOD_DAWN     = 3'd0,
        PERIOD_DAY      = 3'd1,
        PERIOD_DUSK     = 3'd2,
        PERIOD_NIGHT    = 3'd3,
        PERIOD_MIDNIGHT = 3'd4,
        PERIOD_PREDAWN  = 3'd5
    } t_period;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INC,
        S_UPDATE,
        S_SEG,
        S_MUL,
        S_LOAD,
        S_CDIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [REM_BITS-1:0]   rem_init;
        logic [SRC_BITS-1:0]   src;
        logic [DUR_BITS-1:0]   divisor;
        logic [STEP_BITS-1:0]  steps;
    } t_div_ctrl;

    typedef struct packed {
        logic                  busy;
        logic [SRC_BITS-1:0]   quot;
    } t_div_stat;

    typedef struct packed {
        logic [PHASE_BITS-1:0]  time_of_day;
        logic [DAY_BITS-1:0]    day_number;
        logic                   is_night;
        logic [PERIOD_BITS-1:0] period;
        logic [CHAN_BITS-1:0]   red;
        logic [CHAN_BITS-1:0]   green;
        logic [CHAN_BITS-1:0]   blue;
        logic [CHAN_BITS-1:0]   alpha;
    } t_result;

endpackage

`default_nettype wire

### rtl/dpcr_tick_if.sv
// Valid/ready channel carrying one tick transaction.
`default_nettype none

interface dpcr_tick_if import dpcr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ELAPSED_BITS-1:0] elapsed_ms;

    modport source (output valid, output elapsed_ms, input ready);
    modport sink   (input valid, input elapsed_ms, output ready);
endinterface

`default_nettype wire

### rtl/dpcr_ramp_if.sv
// Valid/ready channel carrying one time-of-day and overlay colour transaction.
`default_nettype none

interface dpcr_ramp_if import dpcr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [PHASE_BITS-1:0]  time_of_day;
    logic [DAY_BITS-1:0]    day_number;
    logic                   is_night;
    logic [PERIOD_BITS-1:0] period;
    logic [CHAN_BITS-1:0]   red;
    logic [CHAN_BITS-1:0]   green;
    logic [CHAN_BITS-1:0]   blue;
    logic [CHAN_BITS-1:0]   alpha;

    modport source (output valid, output time_of_day, output day_number, output is_night,
                    output period, output red, output green, output blue, output alpha,
                    input ready);
    modport sink   (input valid, input time_of_day, input day_number, input is_night,
                    input period, input red, input green, input blue, input alpha,
                    output ready);
endinterface

`default_nettype wire

### rtl/dpcr_div.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module dpcr_div import dpcr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_ctrl i_ctrl,
    output t_div_stat o_stat
);

    logic                 r_busy, n_busy;
    logic [STEP_BITS-1:0] r_cnt, n_cnt;
    logic [REM_BITS-1:0]  r_rem, n_rem;
    logic [SRC_BITS-1:0]  r_src, n_src;
    logic [SRC_BITS-1:0]  r_quot, n_quot;
    logic [DUR_BITS-1:0]  r_div, n_div;

    logic [REM_BITS-1:0]  trial;
    logic                 fits;

    always_comb begin
        trial = {r_rem[REM_BITS-2:0], r_src[SRC_BITS-1]};
        fits  = (trial >= REM_BITS'(r_div));
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_src  = r_src;
        n_quot = r_quot;
        n_div  = r_div;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = i_ctrl.steps;
            n_rem  = i_ctrl.rem_init;
            n_src  = i_ctrl.src;
            n_quot = '0;
            n_div  = i_ctrl.divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract where the divisor fits
            n_rem  = fits ? (trial - REM_BITS'(r_div)) : trial;
            n_src  = {r_src[SRC_BITS-2:0], 1'b0};
            n_quot = {r_quot[SRC_BITS-2:0], fits};
            n_cnt  = r_cnt - STEP_BITS'(1);
            n_busy = (r_cnt != STEP_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_src  <= n_src;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quot = r_quot;

endmodule

`default_nettype wire

### rtl/day_phase_color_ramp.sv
// Top level: time-of-day tracker with a keyframed RGBA overlay ramp.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+------------------------------------------
//   i_tick   | in  | valid / ready      | elapsed_ms
//   o_ramp   | out | valid / ready      | time_of_day, day_number, is_night,
//            |     |                    | period, red, green, blue, alpha
//   APB      | in  | psel/penable/pready| day_duration_ms at byte address 0
//
// A tick runs the PHASE_BITS divider steps of the phase increment, then the update
// and segment search, then for each of the four colour channels a multiply, a load,
// eight divider steps and a write back, and finally the load of the output register.
// i_tick.ready is high only while the sequencer is idle; a result waiting in the
// output register does not hold off the next tick, but a finished tick waits for it.
// Reset is synchronous and active low; it restores the day length, phase and day count.
`default_nettype none

module day_phase_color_ramp import dpcr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    dpcr_tick_if.sink                i_tick,
    dpcr_ramp_if.source              o_ramp,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    function automatic logic at_or_past(input logic [SCALED_BITS-1:0] scaled,
                                        input logic [PCT_BITS-1:0] hundredths);
        logic [SCALED_BITS-1:0] lim;
        lim = SCALED_BITS'(hundredths) << PHASE_BITS;
        return scaled >= lim;
    endfunction

    t_state r_state, n_state;

    logic [DUR_BITS-1:0]      r_dur;
    logic [PHASE_BITS-1:0]    r_phase, n_phase;
    logic [DAY_BITS-1:0]      r_day, n_day;
    logic                     r_sat, n_sat;
    logic [SEG_BITS-1:0]      r_seg, n_seg;
    logic [OFF_BITS-1:0]      r_off, n_off;
    logic [CHAN_IDX_BITS-1:0] r_chan, n_chan;
    logic [PROD_BITS-1:0]     r_prod, n_prod;
    logic [CHAN_BITS-1:0]     r_base, n_base;
    logic [CHAN_BITS-1:0]     r_col [NUM_CHANS];
    t_result                  r_res, n_res;
    logic                     r_out_valid, n_out_valid;

    t_div_ctrl div_ctrl;
    t_div_stat div_stat;

    logic                   tick_accept;
    logic                   out_take;
    logic                   cfg_write;
    logic                   res_load;
    logic [DUR_BITS-1:0]    dur_eff;
    logic [PHASE_BITS-1:0]  inc;
    logic [PHASE_BITS:0]    sum;
    logic [SCALED_BITS-1:0] scaled;
    logic [SEG_BITS-1:0]    seg_of;
    logic [CHAN_BITS-1:0]   key_a, key_b, delta;
    logic                   rising;
    logic [OFF_BITS-1:0]    den, weight;
    logic [X_BITS-1:0]      x;
    t_period                period_now;

    dpcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .o_stat  (div_stat)
    );

    // APB: one register, writes elsewhere are dropped
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[APB_ADDR_BITS-1:2] == REG_DAY_DURATION);
    assign prdata    = (paddr[APB_ADDR_BITS-1:2] == REG_DAY_DURATION) ?
                       APB_DATA_BITS'(r_dur) : '0;

    assign dur_eff     = (r_dur == '0) ? DUR_DEFAULT : r_dur;
    assign tick_accept = i_tick.valid && i_tick.ready;
    assign out_take    = r_out_valid && o_ramp.ready;
    assign res_load    = (r_state == S_DONE) && (!r_out_valid || o_ramp.ready);

    // Phase arithmetic, segment search and thresholds
    always_comb begin
        inc    = r_sat ? '1 : div_stat.quot[PHASE_BITS-1:0];
        sum    = {1'b0, r_phase} + {1'b0, inc};
        scaled = SCALED_BITS'(r_phase) * SCALED_BITS'(100);
        seg_of = SEG_BITS'(SEG_COUNT - 1);
        for (int i = SEG_COUNT - 2; i >= 0; i--) begin
            if (scaled < (SCALED_BITS'(KEY_POS[i + 1]) << PHASE_BITS)) begin
                seg_of = SEG_BITS'(i);
            end
        end
        if (!at_or_past(scaled, BRK_DAY)) begin
            period_now = PERIOD_DAWN;
        end else if (!at_or_past(scaled, BRK_DUSK)) begin
            period_now = PERIOD_DAY;
        end else if (!at_or_past(scaled, BRK_NIGHT)) begin
            period_now = PERIOD_DUSK;
        end else if (!at_or_past(scaled, BRK_MIDNIGHT)) begin
            period_now = PERIOD_NIGHT;
        end else if (!at_or_past(scaled, BRK_PREDAWN)) begin
            period_now = PERIOD_MIDNIGHT;
        end else begin
            period_now = PERIOD_PREDAWN;
        end
    end

    // Colour channel: walk the falling side from the far key so the product stays
    // non-negative.
    always_comb begin
        key_a  = KEY_RGBA[r_seg][r_chan];
        key_b  = KEY_RGBA[r_seg + SEG_BITS'(1)][r_chan];
        rising = (key_b >= key_a);
        delta  = rising ? (key_b - key_a) : (key_a - key_b);
        den    = OFF_BITS'(SEG_SPAN[r_seg]) << PHASE_BITS;
        weight = rising ? r_off : (den - r_off);
        x      = r_prod[PHASE_BITS +: X_BITS];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (tick_accept) n_state = S_INC;
            S_INC:    if (!div_stat.busy) n_state = S_UPDATE;
            S_UPDATE: n_state = S_SEG;
            S_SEG:    n_state = S_MUL;
            S_MUL:    n_state = S_LOAD;
            S_LOAD:   n_state = S_CDIV;
            S_CDIV: begin
                if (!div_stat.busy) begin
                    n_state = (r_chan == CHAN_IDX_BITS'(NUM_CHANS - 1)) ? S_DONE : S_MUL;
                end
            end
            S_DONE:   if (res_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        i_tick.ready      = 1'b0;
        div_ctrl.start    = 1'b0;
        div_ctrl.rem_init = REM_BITS'(i_tick.elapsed_ms);
        div_ctrl.src      = '0;
        div_ctrl.divisor  = dur_eff;
        div_ctrl.steps    = STEP_BITS'(PHASE_BITS);
        case (r_state)
            S_IDLE: begin
                i_tick.ready   = 1'b1;
                div_ctrl.start = tick_accept;
            end
            S_LOAD: begin
                div_ctrl.start    = 1'b1;
                div_ctrl.rem_init = REM_BITS'(x[X_BITS-1:CHAN_BITS]);
                div_ctrl.src      = SRC_BITS'(x[CHAN_BITS-1:0]) << (SRC_BITS - CHAN_BITS);
                div_ctrl.divisor  = DUR_BITS'(SEG_SPAN[r_seg]);
                div_ctrl.steps    = STEP_BITS'(CHAN_BITS);
            end
            default: begin
                div_ctrl.start = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_phase     = r_phase;
        n_day       = r_day;
        n_sat       = r_sat;
        n_seg       = r_seg;
        n_off       = r_off;
        n_chan      = r_chan;
        n_prod      = r_prod;
        n_base      = r_base;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        if (out_take) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_sat = ({{(DUR_BITS - ELAPSED_BITS){1'b0}}, i_tick.elapsed_ms} >= dur_eff);
            end
            S_UPDATE: begin
                n_phase = sum[PHASE_BITS-1:0];
                if (sum[PHASE_BITS]) begin
                    n_day = r_day + DAY_BITS'(1);
                end
                n_chan = '0;
            end
            S_SEG: begin
                n_seg = seg_of;
                n_off = OFF_BITS'(scaled - (SCALED_BITS'(KEY_POS[seg_of]) << PHASE_BITS));
            end
            S_MUL: begin
                n_prod = PROD_BITS'(delta) * PROD_BITS'(weight);
                n_base = rising ? key_a : key_b;
            end
            S_CDIV: begin
                if (!div_stat.busy) begin
                    n_chan = r_chan + CHAN_IDX_BITS'(1);
                end
            end
            S_DONE: begin
                if (res_load) begin
                    n_res.time_of_day = r_phase;
                    n_res.day_number  = r_day;
                    n_res.is_night    = at_or_past(scaled, NIGHT_START) &&
                                        !at_or_past(scaled, BRK_PREDAWN);
                    n_res.period      = period_now;
                    n_res.red         = r_col[0];
                    n_res.green       = r_col[1];
                    n_res.blue        = r_col[2];
                    n_res.alpha       = r_col[3];
                    n_out_valid       = 1'b1;
                end
            end
            default: begin
                n_chan = r_chan;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dur       <= DUR_DEFAULT;
            r_phase     <= PHASE_RESET;
            r_day       <= DAY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_day       <= n_day;
            r_out_valid <= n_out_valid;
            if (cfg_write) begin
                r_dur <= pwdata[DUR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sat  <= n_sat;
        r_seg  <= n_seg;
        r_off  <= n_off;
        r_chan <= n_chan;
        r_prod <= n_prod;
        r_base <= n_base;
        r_res  <= n_res;
        if ((r_state == S_CDIV) && !div_stat.busy) begin
            r_col[r_chan] <= r_base + div_stat.quot[CHAN_BITS-1:0];
        end
    end

    assign o_ramp.valid       = r_out_valid;
    assign o_ramp.time_of_day = r_res.time_of_day;
    assign o_ramp.day_number  = r_res.day_number;
    assign o_ramp.is_night    = r_res.is_night;
    assign o_ramp.period      = r_res.period;
    assign o_ramp.red         = r_res.red;
    assign o_ramp.green       = r_res.green;
    assign o_ramp.blue        = r_res.blue;
    assign o_ramp.alpha       = r_res.alpha;

endmodule

`default_nettype wire
